FILE: rtl/pbwft_pkg.sv
// ----------------------------------------------------------------------------
// pbwft_pkg
// Shared types and constants of the protobuf wire field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pbwft_pkg;

    localparam int LEN_WIDTH_DEF    = 32;
    localparam int FIELD_W          = 29;
    localparam int VALUE_W          = 64;
    localparam int KIND_W           = 3;
    localparam int WIRE_W           = 3;
    localparam int COUNT_W          = 4;
    localparam int VARINT_MAX_BYTES = 10;
    localparam int SHIFT_W          = 6;
    localparam int MAX_SHIFT        = 63;
    localparam int FIX64_BYTES      = 8;
    localparam int FIX32_BYTES      = 4;

    // event kinds
    localparam logic [KIND_W-1:0] EV_VARINT = 3'd0;
    localparam logic [KIND_W-1:0] EV_FIX64  = 3'd1;
    localparam logic [KIND_W-1:0] EV_FIX32  = 3'd2;
    localparam logic [KIND_W-1:0] EV_LENHDR = 3'd3;
    localparam logic [KIND_W-1:0] EV_BODY   = 3'd4;
    localparam logic [KIND_W-1:0] EV_ERROR  = 3'd5;

    // wire types
    localparam logic [WIRE_W-1:0] WT_VARINT = 3'd0;
    localparam logic [WIRE_W-1:0] WT_FIX64  = 3'd1;
    localparam logic [WIRE_W-1:0] WT_LEN    = 3'd2;
    localparam logic [WIRE_W-1:0] WT_FIX32  = 3'd5;

    typedef enum logic [6:0] {
        PH_TAG    = 7'b0000001,
        PH_VARINT = 7'b0000010,
        PH_FIX64  = 7'b0000100,
        PH_FIX32  = 7'b0001000,
        PH_LENGTH = 7'b0010000,
        PH_BODY   = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] field_number;
        logic [WIRE_W-1:0]  wire_type;
        logic [VALUE_W-1:0] value;
        logic               end_of_message;
    } t_event;

endpackage

`default_nettype wire

FILE: rtl/protobuf_wire_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// protobuf_wire_field_tokenizer_core
// Streaming protobuf wire-format tokenizer, one message byte per item.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one message byte (i_data_byte) and
// i_message_end, high on the last byte of the message. Output channel:
// o_valid / i_stall carry one field event: kind, field number, wire type,
// 64-bit value and the end-of-message flag.
// Each byte updates the field state in the cycle it is accepted; tag bytes
// and partial varint/fixed bytes produce no event. Length-delimited fields
// give a header event and then one event per body byte.
// Throughput: one byte per cycle while o_stall is low.
// Events are registered in the output register, or in the skid entry while the receiver stalls.
// Stall: the output register plus one skid entry absorb a stalled receiver;
// o_stall rises only when the skid entry holds an event, and clears once the
// receiver takes the output.
// Errors: one error event, then bytes are dropped up to the last byte.
// Reset (synchronous, active low): decoder returns to expecting a tag and
// both output entries empty; the block accepts in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_wire_field_tokenizer_core #(
    parameter int LEN_WIDTH = pbwft_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_message_end,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [pbwft_pkg::KIND_W-1:0]             o_event_kind,
    output logic [pbwft_pkg::FIELD_W-1:0]            o_field_number,
    output logic [pbwft_pkg::WIRE_W-1:0]             o_wire_type,
    output logic [pbwft_pkg::VALUE_W-1:0]            o_value,
    output logic                                     o_end_of_message
);

    logic              accept;
    logic              ev_valid;
    logic              buf_full;
    pbwft_pkg::t_event ev;
    pbwft_pkg::t_event out_ev;

    // take a byte whenever the skid entry is free
    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    pbwft_decoder #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .o_ev_valid    (ev_valid),
        .o_event       (ev)
    );

    // hold events while the receiver stalls
    pbwft_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ev_valid),
        .i_event (ev),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_event (out_ev),
        .i_stall (i_stall)
    );

    assign o_event_kind     = out_ev.kind;
    assign o_field_number   = out_ev.field_number;
    assign o_wire_type      = out_ev.wire_type;
    assign o_value          = out_ev.value;
    assign o_end_of_message = out_ev.end_of_message;

endmodule

`default_nettype wire

FILE: rtl/pbwft_decoder.sv
// ----------------------------------------------------------------------------
// pbwft_decoder
// Field state and one-byte update; produces at most one event per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pbwft_decoder #(
    parameter int LEN_WIDTH = pbwft_pkg::LEN_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_message_end,
    output logic                   o_ev_valid,
    output pbwft_pkg::t_event      o_event
);

    pbwft_pkg::t_phase                  r_phase, n_phase;
    logic [pbwft_pkg::VALUE_W-1:0]      r_accum, n_accum;
    logic [pbwft_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [pbwft_pkg::FIELD_W-1:0]      r_field, n_field;
    logic [pbwft_pkg::WIRE_W-1:0]       r_wire, n_wire;
    logic [LEN_WIDTH-1:0]               r_remaining, n_remaining;

    logic [pbwft_pkg::SHIFT_W-1:0]      vshift;
    logic [pbwft_pkg::VALUE_W-1:0]      vin;
    logic [pbwft_pkg::VALUE_W-1:0]      fin;
    logic [pbwft_pkg::COUNT_W-1:0]      cnt_inc;
    logic [pbwft_pkg::COUNT_W-1:0]      need;
    logic [LEN_WIDTH-1:0]               rem_dec;
    logic                               err;
    logic                               ev_hit;
    logic [pbwft_pkg::KIND_W-1:0]       ev_kind;
    logic [pbwft_pkg::VALUE_W-1:0]      ev_val;

    // varint group placement; the tenth byte keeps only its low bit
    always_comb begin
        if (r_count >= pbwft_pkg::COUNT_W'(pbwft_pkg::VARINT_MAX_BYTES - 1)) begin
            vshift = pbwft_pkg::SHIFT_W'(pbwft_pkg::MAX_SHIFT);
        end else begin
            vshift = pbwft_pkg::SHIFT_W'(r_count) * pbwft_pkg::SHIFT_W'(7);
        end
    end

    assign vin     = r_accum | ({57'd0, i_data_byte[6:0]} << vshift);
    assign fin     = r_accum | ({56'd0, i_data_byte} << {r_count[2:0], 3'b000});
    assign cnt_inc = r_count + pbwft_pkg::COUNT_W'(1);
    assign need    = (r_phase == pbwft_pkg::PH_FIX64) ?
                     pbwft_pkg::COUNT_W'(pbwft_pkg::FIX64_BYTES) :
                     pbwft_pkg::COUNT_W'(pbwft_pkg::FIX32_BYTES);
    assign rem_dec = (r_remaining != '0) ? r_remaining - LEN_WIDTH'(1) : r_remaining;

    always_comb begin
        n_phase     = r_phase;
        n_accum     = r_accum;
        n_count     = r_count;
        n_field     = r_field;
        n_wire      = r_wire;
        n_remaining = r_remaining;
        err         = 1'b0;
        ev_hit      = 1'b0;
        ev_kind     = pbwft_pkg::EV_VARINT;
        ev_val      = '0;

        if (r_phase == pbwft_pkg::PH_ERROR) begin
            // drop bytes until the message ends
            if (i_message_end) begin
                n_phase     = pbwft_pkg::PH_TAG;
                n_accum     = '0;
                n_count     = '0;
                n_remaining = '0;
            end
        end else begin
            case (r_phase)
                pbwft_pkg::PH_TAG, pbwft_pkg::PH_VARINT, pbwft_pkg::PH_LENGTH: begin
                    n_accum = vin;
                    if (i_data_byte[7]) begin
                        if (r_count == pbwft_pkg::COUNT_W'(pbwft_pkg::VARINT_MAX_BYTES - 1))
                        begin
                            if (r_phase == pbwft_pkg::PH_TAG) begin
                                n_field = '0;
                                n_wire  = '0;
                            end
                            err = 1'b1;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end else begin
                        n_accum = '0;
                        n_count = '0;
                        if (r_phase == pbwft_pkg::PH_TAG) begin
                            n_field = vin[pbwft_pkg::FIELD_W+2:3];
                            n_wire  = vin[2:0];
                            case (vin[2:0])
                                pbwft_pkg::WT_VARINT: n_phase = pbwft_pkg::PH_VARINT;
                                pbwft_pkg::WT_FIX64:  n_phase = pbwft_pkg::PH_FIX64;
                                pbwft_pkg::WT_LEN:    n_phase = pbwft_pkg::PH_LENGTH;
                                pbwft_pkg::WT_FIX32:  n_phase = pbwft_pkg::PH_FIX32;
                                default:              err     = 1'b1;
                            endcase
                        end else if (r_phase == pbwft_pkg::PH_VARINT) begin
                            ev_hit  = 1'b1;
                            ev_kind = pbwft_pkg::EV_VARINT;
                            ev_val  = vin;
                            n_phase = pbwft_pkg::PH_TAG;
                        end else if (|vin[pbwft_pkg::VALUE_W-1:LEN_WIDTH-1]) begin
                            err = 1'b1;
                        end else begin
                            ev_hit      = 1'b1;
                            ev_kind     = pbwft_pkg::EV_LENHDR;
                            ev_val      = vin;
                            n_remaining = vin[LEN_WIDTH-1:0];
                            n_phase     = (vin != '0) ? pbwft_pkg::PH_BODY : pbwft_pkg::PH_TAG;
                        end
                    end
                end
                pbwft_pkg::PH_FIX64, pbwft_pkg::PH_FIX32: begin
                    n_accum = fin;
                    n_count = cnt_inc;
                    if (cnt_inc >= need) begin
                        ev_hit  = 1'b1;
                        ev_kind = (r_phase == pbwft_pkg::PH_FIX64) ?
                                  pbwft_pkg::EV_FIX64 : pbwft_pkg::EV_FIX32;
                        ev_val  = fin;
                        n_accum = '0;
                        n_count = '0;
                        n_phase = pbwft_pkg::PH_TAG;
                    end
                end
                pbwft_pkg::PH_BODY: begin
                    ev_hit      = 1'b1;
                    ev_kind     = pbwft_pkg::EV_BODY;
                    ev_val      = {56'd0, i_data_byte};
                    n_remaining = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = pbwft_pkg::PH_TAG;
                    end
                end
                default: begin
                    n_phase = pbwft_pkg::PH_TAG;
                end
            endcase

            // last byte must close the field
            if (!err && i_message_end &&
                (n_phase != pbwft_pkg::PH_TAG || n_count != '0)) begin
                err = 1'b1;
            end

            if (err) begin
                ev_hit      = 1'b1;
                ev_kind     = pbwft_pkg::EV_ERROR;
                ev_val      = '0;
                n_phase     = i_message_end ? pbwft_pkg::PH_TAG : pbwft_pkg::PH_ERROR;
                n_accum     = '0;
                n_count     = '0;
                n_remaining = '0;
            end
        end
    end

    assign o_ev_valid              = i_accept && ev_hit;
    assign o_event.kind            = ev_kind;
    assign o_event.field_number    = n_field;
    assign o_event.wire_type       = n_wire;
    assign o_event.value           = ev_val;
    assign o_event.end_of_message  = i_message_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pbwft_pkg::PH_TAG;
            r_accum     <= '0;
            r_count     <= '0;
            r_field     <= '0;
            r_wire      <= '0;
            r_remaining <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_accum     <= n_accum;
            r_count     <= n_count;
            r_field     <= n_field;
            r_wire      <= n_wire;
            r_remaining <= n_remaining;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pbwft_out_buf.sv
// ----------------------------------------------------------------------------
// pbwft_out_buf
// Output register with a skid entry; keeps the stall path registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pbwft_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire pbwft_pkg::t_event  i_event,
    output logic                    o_full,
    output logic                    o_valid,
    output pbwft_pkg::t_event       o_event,
    input  wire logic               i_stall
);

    logic              r_out_valid;
    logic              r_skid_valid;
    pbwft_pkg::t_event r_out;
    pbwft_pkg::t_event r_skid;
    logic              out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_event;
        end else if (i_valid) begin
            r_skid <= i_event;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_event = r_out;

endmodule

`default_nettype wire

FILE: tb/sv/tb_protobuf_wire_field_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_protobuf_wire_field_tokenizer_core
// Self-checking bench for the streaming protobuf wire-format tokenizer.
// ----------------------------------------------------------------------------
// A directed table runs every field kind, the field and value extremes and
// each error path. Randomly built messages follow: mostly well-formed
// fields with random content, plus truncated, corrupted and noise messages.
// A cycle-free token predictor computes the expected event for every
// accepted byte. Sender idling and receiver stalls vary over four phases.
// ----------------------------------------------------------------------------

module tb_protobuf_wire_field_tokenizer_core;

    import pbwft_pkg::*;

    // Wire types that the block must reject (group start/end, reserved).
    localparam logic [WIRE_W-1:0] WT_SGROUP = 3'd3;
    localparam logic [WIRE_W-1:0] WT_EGROUP = 3'd4;
    localparam logic [WIRE_W-1:0] WT_RSVD6  = 3'd6;
    localparam logic [WIRE_W-1:0] WT_RSVD7  = 3'd7;

    localparam t_event NO_EVENT       = '0;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS       = 500;
    localparam int ITEMS_PER_PHASE    = 125;

    // Directed row: one byte, its last-byte flag, and an optional typed-in event.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_event     ev;
    } t_row;

    localparam int N_DIR = 51;

    t_row dir_tab [N_DIR] = '{
        // field 0, fixed32 0x12345678 (checked by the predictor)
        {8'h05, 1'b0, 1'b0, NO_EVENT},
        {8'h78, 1'b0, 1'b0, NO_EVENT},
        {8'h56, 1'b0, 1'b0, NO_EVENT},
        {8'h34, 1'b0, 1'b0, NO_EVENT},
        {8'h12, 1'b0, 1'b0, NO_EVENT},
        // field 1, fixed64 all ones
        {8'h09, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b1, EV_FIX64, 29'd1, WT_FIX64, ALL_ONES, 1'b0},
        // field 2, length 1, one body byte
        {8'h12, 1'b0, 1'b0, NO_EVENT},
        {8'h01, 1'b0, 1'b0, NO_EVENT},
        {8'hAB, 1'b0, 1'b0, NO_EVENT},
        // largest field number, ten-byte varint of all ones, ends the message
        {8'hF8, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'h0F, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'hFF, 1'b0, 1'b0, NO_EVENT},
        {8'h01, 1'b1, 1'b1, EV_VARINT, 29'h1FFF_FFFF, WT_VARINT, ALL_ONES, 1'b1},
        // bad wire type mid-message; the last byte after it is dropped
        {8'h0B, 1'b0, 1'b1, EV_ERROR, 29'd1, WT_SGROUP, 64'd0, 1'b0},
        {8'h08, 1'b1, 1'b0, NO_EVENT},
        // message ends right after a tag
        {8'h08, 1'b1, 1'b1, EV_ERROR, 29'd1, WT_VARINT, 64'd0, 1'b1},
        // overlong tag: tenth byte still continues, tag fields read as zero
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b1, 1'b1, EV_ERROR, 29'd0, WT_VARINT, 64'd0, 1'b1},
        // length of exactly 2^31 on field 2
        {8'h12, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h80, 1'b0, 1'b0, NO_EVENT},
        {8'h08, 1'b1, 1'b1, EV_ERROR, 29'd2, WT_LEN, 64'd0, 1'b1}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic [7:0]           i_data_byte   = 8'h00;
    logic                 i_message_end = 1'b0;
    logic                 i_stall       = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [KIND_W-1:0]    o_event_kind;
    logic [FIELD_W-1:0]   o_field_number;
    logic [WIRE_W-1:0]    o_wire_type;
    logic [VALUE_W-1:0]   o_value;
    logic                 o_end_of_message;

    protobuf_wire_field_tokenizer_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_message_end    (i_message_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_field_number   (o_field_number),
        .o_wire_type      (o_wire_type),
        .o_value          (o_value),
        .o_end_of_message (o_end_of_message)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_event      events_due [$];     // expected events, oldest first
    logic [7:0]  msg_bytes [$];      // message under construction
    int          mismatches     = 0;
    int          bytes_decoded  = 0; // accepted bytes, dropped ones included
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    bit          cur_typed      = 1'b0;
    t_event      cur_exp        = '0;

    // Predictor copy of the tokenizer state.
    t_phase               tok_phase  = PH_TAG;
    logic [63:0]          tok_acc    = '0;
    int unsigned          tok_nbytes = 0;
    logic [FIELD_W-1:0]   tok_field  = '0;
    logic [WIRE_W-1:0]    tok_wire   = '0;
    logic [31:0]          tok_remain = '0;

    // Advance the token predictor by one byte; return 1 when an event results.
    function automatic bit tokenize_byte(input logic [7:0] b, input bit last,
                                         output t_event ev);
        int unsigned  shift;
        int unsigned  need;
        logic [63:0]  v;
        logic [63:0]  val;
        logic [KIND_W-1:0] kind;
        bit           err;
        bit           got;

        ev   = NO_EVENT;
        err  = 1'b0;
        got  = 1'b0;
        val  = '0;
        kind = EV_VARINT;

        // Drop everything after an error; the last byte rearms the decoder.
        if (tok_phase == PH_ERROR) begin
            if (last) begin
                tok_phase  = PH_TAG;
                tok_acc    = '0;
                tok_nbytes = 0;
                tok_remain = '0;
            end
            return 1'b0;
        end

        case (tok_phase)
            PH_TAG, PH_VARINT, PH_LENGTH: begin
                // Only bit 0 of a tenth varint byte lands, at bit 63.
                shift = 7 * (tok_nbytes % VARINT_MAX_BYTES);
                if (shift > MAX_SHIFT) shift = MAX_SHIFT;
                tok_acc |= 64'(b[6:0]) << shift;
                if (b[7]) begin
                    if (tok_nbytes + 1 >= VARINT_MAX_BYTES) begin
                        if (tok_phase == PH_TAG) begin
                            tok_field = '0;
                            tok_wire  = '0;
                        end
                        err = 1'b1;
                    end else begin
                        tok_nbytes++;
                    end
                end else begin
                    v          = tok_acc;
                    tok_acc    = '0;
                    tok_nbytes = 0;
                    if (tok_phase == PH_TAG) begin
                        tok_field = v[31:3];
                        tok_wire  = v[2:0];
                        case (tok_wire)
                            WT_VARINT: tok_phase = PH_VARINT;
                            WT_FIX64:  tok_phase = PH_FIX64;
                            WT_LEN:    tok_phase = PH_LENGTH;
                            WT_FIX32:  tok_phase = PH_FIX32;
                            default:   err = 1'b1;
                        endcase
                    end else if (tok_phase == PH_VARINT) begin
                        got       = 1'b1;
                        kind      = EV_VARINT;
                        val       = v;
                        tok_phase = PH_TAG;
                    end else if ((v >> (LEN_WIDTH_DEF - 1)) != 0) begin
                        err = 1'b1;
                    end else begin
                        got        = 1'b1;
                        kind       = EV_LENHDR;
                        val        = v;
                        tok_remain = v[31:0];
                        tok_phase  = (tok_remain != 0) ? PH_BODY : PH_TAG;
                    end
                end
            end
            PH_FIX64, PH_FIX32: begin
                need = (tok_phase == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;
                tok_acc |= 64'(b) << (8 * (tok_nbytes & 7));
                tok_nbytes++;
                if (tok_nbytes >= need) begin
                    got        = 1'b1;
                    kind       = (tok_phase == PH_FIX64) ? EV_FIX64 : EV_FIX32;
                    val        = tok_acc;
                    tok_acc    = '0;
                    tok_nbytes = 0;
                    tok_phase  = PH_TAG;
                end
            end
            default: begin
                // body byte of a length-delimited field
                got  = 1'b1;
                kind = EV_BODY;
                val  = 64'(b);
                if (tok_remain != 0) tok_remain--;
                if (tok_remain == 0) tok_phase = PH_TAG;
            end
        endcase

        // A last byte that leaves a tag or field open is an error.
        if (!err && last && (tok_phase != PH_TAG || tok_nbytes != 0)) err = 1'b1;

        if (err) begin
            ev         = '{EV_ERROR, tok_field, tok_wire, 64'd0, last};
            tok_phase  = last ? PH_TAG : PH_ERROR;
            tok_acc    = '0;
            tok_nbytes = 0;
            tok_remain = '0;
            return 1'b1;
        end
        if (got) begin
            ev = '{kind, tok_field, tok_wire, val, last};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare one received event with the oldest expected one, field by field.
    task automatic check_event(input t_event want, input t_event got);
        if (got.kind !== want.kind) begin
            $display("[%0t] mismatch event_kind: expected %0d, got %0d",
                     $time, want.kind, got.kind);
            mismatches++;
        end
        if (got.field_number !== want.field_number) begin
            $display("[%0t] mismatch field_number: expected %0d, got %0d",
                     $time, want.field_number, got.field_number);
            mismatches++;
        end
        if (got.wire_type !== want.wire_type) begin
            $display("[%0t] mismatch wire_type: expected %0d, got %0d",
                     $time, want.wire_type, got.wire_type);
            mismatches++;
        end
        if (got.value !== want.value) begin
            $display("[%0t] mismatch value: expected %h, got %h",
                     $time, want.value, got.value);
            mismatches++;
        end
        if (got.end_of_message !== want.end_of_message) begin
            $display("[%0t] mismatch end_of_message: expected %0b, got %0b",
                     $time, want.end_of_message, got.end_of_message);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check the output item first, then predict from the input
    // item taken at the same edge. Outputs are registered, so an event
    // is never checked against the expectation queued in its own edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_event got_ev;
        t_event pred_ev;
        bit     has_ev;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got_ev = '{o_event_kind, o_field_number, o_wire_type, o_value,
                           o_end_of_message};
                if (events_due.size() == 0) begin
                    $display("[%0t] unexpected event: expected none, got kind %0d field %0d value %h",
                             $time, o_event_kind, o_field_number, o_value);
                    mismatches++;
                end else begin
                    check_event(events_due.pop_front(), got_ev);
                end
            end
            if (i_valid && !o_stall) begin
                bytes_decoded++;
                has_ev = tokenize_byte(i_data_byte, i_message_end, pred_ev);
                // A typed-in row overrides the predictor; the predictor
                // still advances so its state tracks the stream.
                if (cur_typed) events_due.insert(events_due.size(), cur_exp);
                else if (has_ev) events_due.insert(events_due.size(), pred_ev);
            end
        end
    end

    // Receiver: stall at random per the current idling phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte; return at the falling edge after it is taken.
    task automatic send_byte(input logic [7:0] b, input bit last,
                             input bit typed, input t_event ev);
        // Idle the sender, scrambling the payload while valid is low.
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid       <= 1'b0;
            i_data_byte   <= 8'($urandom);
            i_message_end <= 1'($urandom);
            @(negedge i_clk);
        end
        cur_typed      = typed;
        cur_exp        = ev;
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_message_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected event has come out.
    task automatic drain_events();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (events_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(input int phase_no);
        case (phase_no)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 63; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 63; end
            default: begin src_idle_pct = 10; sink_stall_pct = 10; end
        endcase
    endtask

    // Append one byte to the message under construction.
    function automatic void add_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    // Append a varint, padded with continuation groups to min_len bytes.
    function automatic void add_varint(input logic [63:0] v, input int min_len);
        logic [63:0] rest;
        logic [7:0]  grp;
        bit          more;
        rest = v;
        for (int i = 0; i < VARINT_MAX_BYTES; i++) begin
            grp  = {1'b0, rest[6:0]};
            rest = rest >> 7;
            more = ((rest != 0) || (i + 1 < min_len)) && (i < VARINT_MAX_BYTES - 1);
            // bits 6..1 of a tenth byte are dropped: fill them with junk
            if (i == VARINT_MAX_BYTES - 1) grp[6:1] = 6'($urandom);
            grp[7] = more;
            add_byte(grp);
            if (!more) break;
        end
    endfunction

    function automatic int rand_pad();
        return ($urandom_range(7) == 0) ? $urandom_range(1, VARINT_MAX_BYTES) : 0;
    endfunction

    // Build one random message: mostly well-formed fields, some broken.
    function automatic void build_message();
        int                 style;
        int                 nf;
        int                 len;
        int                 cut;
        logic [WIRE_W-1:0]  wt;
        logic [FIELD_W-1:0] fn;
        logic [63:0]        tagv;
        logic [63:0]        v;

        msg_bytes.delete();
        style = $urandom_range(99);
        fn    = '0;

        // pure noise
        if (style < 8) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
            return;
        end

        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            case ($urandom_range(3))
                0:       wt = WT_VARINT;
                1:       wt = WT_FIX64;
                2:       wt = WT_LEN;
                default: wt = WT_FIX32;
            endcase
            fn = ($urandom_range(3) == 0) ? FIELD_W'($urandom)
                                          : FIELD_W'($urandom_range(0, 20));
            tagv = 64'({fn, wt});
            // tag with upper bits beyond the field number, truncated away
            if ($urandom_range(15) == 0) begin
                tagv      = {$urandom, $urandom};
                tagv[2:0] = wt;
            end
            add_varint(tagv, rand_pad());
            case (wt)
                WT_VARINT: begin
                    v = {$urandom, $urandom} >> $urandom_range(63);
                    add_varint(v, rand_pad());
                end
                WT_FIX64: repeat (FIX64_BYTES) add_byte(8'($urandom));
                WT_FIX32: repeat (FIX32_BYTES) add_byte(8'($urandom));
                default: begin
                    len = ($urandom_range(19) == 0) ? $urandom_range(7, 40)
                                                    : $urandom_range(0, 6);
                    add_varint(64'(len), rand_pad());
                    repeat (len) add_byte(8'($urandom));
                end
            endcase
        end

        if (style < 22) begin
            // truncate inside or between fields
            if (msg_bytes.size() > 1) begin
                cut = $urandom_range(1, msg_bytes.size() - 1);
                repeat (cut) void'(msg_bytes.pop_back());
            end
        end else if (style < 28) begin
            // field with a rejected wire type, then trailing junk
            case ($urandom_range(3))
                0:       wt = WT_SGROUP;
                1:       wt = WT_EGROUP;
                2:       wt = WT_RSVD6;
                default: wt = WT_RSVD7;
            endcase
            add_varint(64'({fn, wt}), 0);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
        end else if (style < 34) begin
            // overlong varint as a tag, or as a value or length after a tag
            if ($urandom_range(1))
                add_varint(64'({fn, ($urandom_range(1) ? WT_VARINT : WT_LEN)}), 0);
            repeat ($urandom_range(10, 12))
                add_byte(8'h80 | 8'($urandom_range(127)));
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        end else if (style < 40) begin
            // length at or above 2^31
            add_varint(64'({fn, WT_LEN}), 0);
            v = {$urandom, $urandom} | (64'd1 << $urandom_range(31, 63));
            add_varint(v, 0);
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int idle_phase;
        int n;

        idle_phase = 0;
        set_idling(0);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, no idling.
        for (int r = 0; r < N_DIR; r++)
            send_byte(dir_tab[r].data, dir_tab[r].last, dir_tab[r].typed, dir_tab[r].ev);
        drain_events();

        // Random messages; advance the idling phase every so many bytes,
        // draining the block at each switch.
        bytes_decoded = 0;
        while (bytes_decoded < RANDOM_ITEMS) begin
            build_message();
            n = msg_bytes.size();
            for (int k = 0; k < n; k++)
                send_byte(msg_bytes[k], (k == n - 1), 1'b0, NO_EVENT);
            if (idle_phase < 3 && bytes_decoded >= (idle_phase + 1) * ITEMS_PER_PHASE) begin
                drain_events();
                idle_phase++;
                set_idling(idle_phase);
            end
        end

        drain_events();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: protobuf_wire_field_tokenizer_core.f
rtl/pbwft_pkg.sv
rtl/pbwft_decoder.sv
rtl/pbwft_out_buf.sv
rtl/protobuf_wire_field_tokenizer_core.sv
tb/sv/tb_protobuf_wire_field_tokenizer_core.sv
